### sv/kntc_pkg.sv
package kntc_pkg;

   // word length limit and the width of the length counter
   localparam int MAX_COUNT = 255;
   localparam int WLEN_W    = $clog2(MAX_COUNT + 1);

   // keyword table
   localparam int NUM_KW     = 13;
   localparam int KW_MAX_LEN = 8;
   localparam int KW_IDX_W   = 4;

   localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
      '{"I", "N", "T", "E", "G", "E", "R", 8'h00},
      '{"B", "E", "G", "I", "N", 8'h00, 8'h00, 8'h00},
      '{"R", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"I", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"E", "L", "S", "E", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"T", "H", "E", "N", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"E", "N", "D", "I", "F", 8'h00, 8'h00, 8'h00},
      '{"W", "H", "I", "L", "E", 8'h00, 8'h00, 8'h00},
      '{"D", "O", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"E", "N", "D", "W", "H", "I", "L", "E"},
      '{"W", "R", "I", "T", "E", 8'h00, 8'h00, 8'h00},
      '{"P", "R", "O", "G", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"E", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [3:0] KW_LEN [NUM_KW] = '{
      4'd7, 4'd5, 4'd4, 4'd2, 4'd4, 4'd4, 4'd5, 4'd5, 4'd2, 4'd8, 4'd5, 4'd4, 4'd3
   };

   // token classes
   localparam logic [1:0] CLASS_KEYWORD    = 2'd0;
   localparam logic [1:0] CLASS_NUMBER     = 2'd1;
   localparam logic [1:0] CLASS_IDENTIFIER = 2'd2;
   localparam logic [1:0] CLASS_OPERATOR   = 2'd3;

   // character codes
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_GT      = 8'h3E;
   localparam logic [7:0] CHAR_LT      = 8'h3C;
   localparam logic [7:0] CHAR_EQ      = 8'h3D;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_VT      = 8'h0B;
   localparam logic [7:0] CHAR_FF      = 8'h0C;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // result queue sizing
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_WORD,
      KIND_OPERATOR,
      KIND_SPACE
   } char_kind_type;

   typedef struct packed {
      logic [1:0]          token_class;
      logic [KW_IDX_W-1:0] keyword_number;
      logic [7:0]          operator_code;
      logic [7:0]          token_length;
      logic                last_of_run;
   } rsp_item_type;

   // low 8 bits of the word length
   function automatic logic [7:0] length_byte(input logic [WLEN_W-1:0] wlen);
      logic [31:0] wide;
      wide = 32'(wlen);
      return wide[7:0];
   endfunction

endpackage

### sv/keyword_number_token_classifier_unit.sv
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | req_char_byte, req_end_of_text
// rsp     | out       | rsp_valid/rsp_stall | rsp_token_class, rsp_keyword_number,
//         |           |                     | rsp_operator_code, rsp_token_length,
//         |           |                     | rsp_last_of_run
//
// one byte is taken per cycle while req_stall is low; its results are queued and
// rsp shows the queue head; a byte gives at most two results, so an operator right
// after a word gives two; rsp drains one result per cycle from a 4-entry queue
// while rsp_stall is low; req_stall is high while fewer than two queue entries are
// free; reset clears the pending word and empties the result queue
module keyword_number_token_classifier_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_token_class,
   output logic [3:0] rsp_keyword_number,
   output logic [7:0] rsp_operator_code,
   output logic [7:0] rsp_token_length,
   output logic       rsp_last_of_run
);

   // pending word state
   logic [kntc_pkg::WLEN_W-1:0] wlen_ff, wlen_in;
   logic [kntc_pkg::NUM_KW-1:0] cand_ff, cand_in;
   logic [1:0]                  dots_ff, dots_in;
   logic                        numok_ff, numok_in;

   // result queue
   kntc_pkg::rsp_item_type       queue_ff [kntc_pkg::Q_DEPTH];
   logic [kntc_pkg::Q_PTR_W-1:0] head_ff, head_in;
   logic [kntc_pkg::Q_PTR_W-1:0] tail_ff, tail_in;
   logic [kntc_pkg::Q_CNT_W-1:0] count_ff, count_in;

   kntc_pkg::char_kind_type     kind;
   logic                        accept;
   logic                        pop;
   logic [7:0]                  upper;
   logic                        is_digit;
   logic [kntc_pkg::WLEN_W-1:0] wlen_app;
   logic [kntc_pkg::NUM_KW-1:0] cand_app;
   logic [1:0]                  dots_app;
   logic                        numok_app;
   logic [kntc_pkg::WLEN_W-1:0] wlen_src;
   logic [kntc_pkg::NUM_KW-1:0] cand_src;
   logic                        numok_src;
   logic                        kw_hit;
   logic [kntc_pkg::KW_IDX_W-1:0] kw_idx;
   kntc_pkg::rsp_item_type      word_item;
   kntc_pkg::rsp_item_type      op_item;
   kntc_pkg::rsp_item_type      res0;
   kntc_pkg::rsp_item_type      res1;
   logic [1:0]                  push_n;
   logic                        clear_word;

   // handshake
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (count_ff != '0);
   assign req_stall = (count_ff > kntc_pkg::Q_CNT_W'(kntc_pkg::Q_DEPTH - 2));

   // character kind
   always_comb begin
      case (req_char_byte) inside
         kntc_pkg::CHAR_PLUS, kntc_pkg::CHAR_MINUS, kntc_pkg::CHAR_STAR,
         kntc_pkg::CHAR_SLASH, kntc_pkg::CHAR_GT, kntc_pkg::CHAR_LT,
         kntc_pkg::CHAR_EQ, kntc_pkg::CHAR_SEMI: kind = kntc_pkg::KIND_OPERATOR;
         kntc_pkg::CHAR_SPACE, kntc_pkg::CHAR_TAB, kntc_pkg::CHAR_LF,
         kntc_pkg::CHAR_VT, kntc_pkg::CHAR_FF, kntc_pkg::CHAR_CR: kind = kntc_pkg::KIND_SPACE;
         default: kind = kntc_pkg::KIND_WORD;
      endcase
   end

   // word state with this byte appended
   always_comb begin
      logic [kntc_pkg::NUM_KW-1:0] cand_base;
      cand_base = (wlen_ff == '0) ? '1 : cand_ff;
      upper = (req_char_byte >= kntc_pkg::CHAR_LOWER_A && req_char_byte <= kntc_pkg::CHAR_LOWER_Z)
              ? req_char_byte - kntc_pkg::CASE_OFFSET : req_char_byte;
      is_digit = (req_char_byte >= kntc_pkg::CHAR_ZERO && req_char_byte <= kntc_pkg::CHAR_NINE);
      for (int k = 0; k < kntc_pkg::NUM_KW; k++) begin
         cand_app[k] = cand_base[k]
                       && (wlen_ff < kntc_pkg::WLEN_W'(kntc_pkg::KW_LEN[k]))
                       && (kntc_pkg::KW_TEXT[k][wlen_ff[2:0]] == upper);
      end
      numok_app = (wlen_ff == '0) ? 1'b1 : numok_ff;
      dots_app  = dots_ff;
      if (req_char_byte == kntc_pkg::CHAR_DOT) begin
         if (dots_ff < 2'd2) begin
            dots_app = dots_ff + 2'd1;
         end
         if (dots_app > 2'd1) begin
            numok_app = 1'b0;
         end
      end else if (!(is_digit || (req_char_byte == kntc_pkg::CHAR_MINUS && wlen_ff == '0))) begin
         numok_app = 1'b0;
      end
      wlen_app = (wlen_ff < kntc_pkg::WLEN_W'(kntc_pkg::MAX_COUNT))
                 ? wlen_ff + kntc_pkg::WLEN_W'(1) : wlen_ff;
   end

   // word being closed: the appended one on end of text, else the pending one
   assign wlen_src  = (kind == kntc_pkg::KIND_WORD) ? wlen_app  : wlen_ff;
   assign cand_src  = (kind == kntc_pkg::KIND_WORD) ? cand_app  : cand_ff;
   assign numok_src = (kind == kntc_pkg::KIND_WORD) ? numok_app : numok_ff;

   // keyword match, lowest index wins
   always_comb begin
      kw_hit = 1'b0;
      kw_idx = '0;
      for (int k = kntc_pkg::NUM_KW - 1; k >= 0; k--) begin
         if (cand_src[k] && wlen_src == kntc_pkg::WLEN_W'(kntc_pkg::KW_LEN[k])) begin
            kw_hit = 1'b1;
            kw_idx = kntc_pkg::KW_IDX_W'(k);
         end
      end
   end

   // result items
   always_comb begin
      word_item.token_class    = kw_hit ? kntc_pkg::CLASS_KEYWORD
                               : (numok_src ? kntc_pkg::CLASS_NUMBER
                                            : kntc_pkg::CLASS_IDENTIFIER);
      word_item.keyword_number = kw_hit ? kw_idx : '0;
      word_item.operator_code  = 8'h00;
      word_item.token_length   = kntc_pkg::length_byte(wlen_src);
      word_item.last_of_run    = 1'b1;

      op_item.token_class    = kntc_pkg::CLASS_OPERATOR;
      op_item.keyword_number = '0;
      op_item.operator_code  = req_char_byte;
      op_item.token_length   = 8'd1;
      op_item.last_of_run    = 1'b1;
   end

   // results for this byte and the next word state
   always_comb begin
      res0       = word_item;
      res1       = op_item;
      push_n     = 2'd0;
      clear_word = 1'b1;
      case (kind)
         kntc_pkg::KIND_OPERATOR: begin
            if (wlen_ff != '0) begin
               res0.last_of_run = 1'b0;
               push_n           = 2'd2;
            end else begin
               res0   = op_item;
               push_n = 2'd1;
            end
         end
         kntc_pkg::KIND_SPACE: begin
            push_n = (wlen_ff != '0) ? 2'd1 : 2'd0;
         end
         default: begin
            push_n     = req_end_of_text ? 2'd1 : 2'd0;
            clear_word = req_end_of_text;
         end
      endcase

      wlen_in  = wlen_ff;
      cand_in  = cand_ff;
      dots_in  = dots_ff;
      numok_in = numok_ff;
      if (accept) begin
         if (clear_word) begin
            wlen_in  = '0;
            cand_in  = '0;
            dots_in  = 2'd0;
            numok_in = 1'b0;
         end else begin
            wlen_in  = wlen_app;
            cand_in  = cand_app;
            dots_in  = dots_app;
            numok_in = numok_app;
         end
      end
   end

   // queue pointers
   always_comb begin
      logic [1:0] pushed;
      pushed   = accept ? push_n : 2'd0;
      tail_in  = tail_ff + kntc_pkg::Q_PTR_W'(pushed);
      head_in  = head_ff + kntc_pkg::Q_PTR_W'(pop);
      count_in = count_ff + kntc_pkg::Q_CNT_W'(pushed) - kntc_pkg::Q_CNT_W'(pop);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff  <= '0;
         cand_ff  <= '0;
         dots_ff  <= 2'd0;
         numok_ff <= 1'b0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         wlen_ff  <= wlen_in;
         cand_ff  <= cand_in;
         dots_ff  <= dots_in;
         numok_ff <= numok_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (accept && push_n != 2'd0) begin
         queue_ff[tail_ff] <= res0;
      end
      if (accept && push_n == 2'd2) begin
         queue_ff[tail_ff + kntc_pkg::Q_PTR_W'(1)] <= res1;
      end
   end

   // output from the queue head
   assign rsp_token_class    = queue_ff[head_ff].token_class;
   assign rsp_keyword_number = queue_ff[head_ff].keyword_number;
   assign rsp_operator_code  = queue_ff[head_ff].operator_code;
   assign rsp_token_length   = queue_ff[head_ff].token_length;
   assign rsp_last_of_run    = queue_ff[head_ff].last_of_run;

`ifndef SYNTHESIS
   // queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= kntc_pkg::Q_CNT_W'(kntc_pkg::Q_DEPTH))
      else $error("result queue overflow");

   // a result that is not last of its run has its partner queued behind it
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> (count_ff >= kntc_pkg::Q_CNT_W'(2)))
      else $error("first of two results without its partner");

   // keyword number only on keywords
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_class != kntc_pkg::CLASS_KEYWORD) |-> (rsp_keyword_number == '0))
      else $error("keyword number on a non-keyword token");

   // operator code only on operators
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_class != kntc_pkg::CLASS_OPERATOR) |-> (rsp_operator_code == 8'h00))
      else $error("operator code on a non-operator token");

   // a space or operator leaves no pending word
   assert property (@(posedge clock) disable iff (reset)
      (accept && kind != kntc_pkg::KIND_WORD) |=> (wlen_ff == '0))
      else $error("word still pending after a separator");
`endif

endmodule
